// ----- design/ffbc_pkg.sv -----
// Shared types and constants of the first-fit block chain allocator.
`default_nettype none
package ffbc_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int SIZE_W      = 16;
   localparam int SUM_W       = 21;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic used;
      logic chained;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [IDX_W-1:0] start;
   } result_type;

endpackage
`default_nettype wire

// ----- design/ffbc_mem.sv -----
// Block mark store: one write port, one registered read port.
`default_nettype none
module ffbc_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ffbc_pkg::IDX_W-1:0]    rd_addr,
   output ffbc_pkg::entry_type                rd_data,
   input  wire ffbc_pkg::mem_wr_type          wr
);

   ffbc_pkg::entry_type                      mem_ff [ffbc_pkg::STORE_DEPTH];
   logic [ffbc_pkg::STORE_DEPTH-1:0]         vld_ff;
   ffbc_pkg::entry_type                      rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   // an entry never written reads as free and unchained
   always_ff @(posedge clock) begin
      if (vld_ff[rd_addr]) begin
         rd_data_ff <= mem_ff[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/ffbc_ctrl.sv -----
// Sequencer: scans the block marks, claims runs and walks chains to free them.
`default_nettype none
module ffbc_ctrl #(
   parameter int SMALL_BLOCKS  = 8,
   parameter int MIDDLE_BLOCKS = 4,
   parameter int LARGE_BLOCKS  = 4,
   parameter int SMALL_BYTES   = 1024,
   parameter int MIDDLE_BYTES  = 2048,
   parameter int LARGE_BYTES   = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_accept,
   input  wire logic                          req_cmd,
   input  wire logic [ffbc_pkg::SIZE_W-1:0]   req_size,
   input  wire logic [ffbc_pkg::IDX_W-1:0]    req_index,
   output logic                               req_ready,
   output logic [ffbc_pkg::IDX_W-1:0]         rd_addr,
   input  wire ffbc_pkg::entry_type           rd_data,
   output ffbc_pkg::mem_wr_type               wr,
   output ffbc_pkg::result_type               result,
   input  wire logic                          result_take
);

   localparam int TOTAL  = SMALL_BLOCKS + MIDDLE_BLOCKS + LARGE_BLOCKS;
   localparam int ACTIVE = (TOTAL < ffbc_pkg::STORE_DEPTH) ? TOTAL : ffbc_pkg::STORE_DEPTH;
   localparam logic [ffbc_pkg::CNT_W-1:0] ACTIVE_CNT = ffbc_pkg::CNT_W'(ACTIVE);
   localparam logic [ffbc_pkg::IDX_W-1:0] LAST_IDX   = ffbc_pkg::IDX_W'(ACTIVE - 1);

   function automatic logic [ffbc_pkg::SIZE_W-1:0] bytes_of(
      input logic [ffbc_pkg::IDX_W-1:0] i
   );
      int ii;
      ii = int'(i);
      if (ii < SMALL_BLOCKS) begin
         return ffbc_pkg::SIZE_W'(SMALL_BYTES);
      end else if (ii < SMALL_BLOCKS + MIDDLE_BLOCKS) begin
         return ffbc_pkg::SIZE_W'(MIDDLE_BYTES);
      end
      return ffbc_pkg::SIZE_W'(LARGE_BYTES);
   endfunction

   ffbc_pkg::state_type               state_ff, state_in;
   logic [ffbc_pkg::CNT_W-1:0]        rd_ff, rd_in;
   logic                              pend_ff, pend_in;
   logic [ffbc_pkg::IDX_W-1:0]        ev_ff, ev_in;
   logic [ffbc_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [ffbc_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic                              run_ff, run_in;
   logic [ffbc_pkg::IDX_W-1:0]        start_ff, start_in;
   logic [ffbc_pkg::IDX_W-1:0]        end_ff, end_in;
   logic [ffbc_pkg::IDX_W-1:0]        wp_ff, wp_in;
   logic                              ok_ff, ok_in;
   logic [ffbc_pkg::SUM_W-1:0]        run_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffbc_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff    <= rd_in;
      ev_ff    <= ev_in;
      size_ff  <= size_in;
      sum_ff   <= sum_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      wp_ff    <= wp_in;
      ok_ff    <= ok_in;
   end

   assign run_sum = (run_ff ? sum_ff : '0) + ffbc_pkg::SUM_W'(bytes_of(ev_ff));

   always_comb begin
      state_in  = state_ff;
      rd_in     = rd_ff;
      pend_in   = 1'b0;
      ev_in     = ev_ff;
      size_in   = size_ff;
      sum_in    = sum_ff;
      run_in    = run_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      wp_in     = wp_ff;
      ok_in     = ok_ff;
      rd_addr   = rd_ff[ffbc_pkg::IDX_W-1:0];
      wr        = '0;
      req_ready = 1'b0;
      result    = '0;

      // read ahead one block a cycle while the walk is running
      if (state_ff == ffbc_pkg::ST_SCAN || state_ff == ffbc_pkg::ST_FREE) begin
         if (rd_ff < ACTIVE_CNT) begin
            pend_in = 1'b1;
            ev_in   = rd_ff[ffbc_pkg::IDX_W-1:0];
            rd_in   = rd_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ffbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = (req_cmd == ffbc_pkg::CMD_FREE) ? req_index : '0;
            if (req_accept) begin
               size_in  = req_size;
               sum_in   = '0;
               run_in   = 1'b0;
               start_in = '0;
               if (req_cmd == ffbc_pkg::CMD_FREE) begin
                  ok_in = 1'b1;
                  if ({1'b0, req_index} < ACTIVE_CNT) begin
                     pend_in  = 1'b1;
                     ev_in    = req_index;
                     rd_in    = {1'b0, req_index} + 1'b1;
                     state_in = ffbc_pkg::ST_FREE;
                  end else begin
                     state_in = ffbc_pkg::ST_DONE;
                  end
               end else begin
                  ok_in = 1'b0;
                  if (req_size == '0 || ACTIVE_CNT == '0) begin
                     state_in = ffbc_pkg::ST_DONE;
                  end else begin
                     pend_in  = 1'b1;
                     ev_in    = '0;
                     rd_in    = ffbc_pkg::CNT_W'(1);
                     state_in = ffbc_pkg::ST_SCAN;
                  end
               end
            end
         end
         ffbc_pkg::ST_SCAN: begin
            if (pend_ff) begin
               if (rd_data.used) begin
                  sum_in = '0;
                  run_in = 1'b0;
               end else begin
                  if (!run_ff) begin
                     start_in = ev_ff;
                  end
                  run_in = 1'b1;
                  sum_in = run_sum;
               end
               if (!rd_data.used && run_sum >= ffbc_pkg::SUM_W'(size_ff)) begin
                  ok_in    = 1'b1;
                  end_in   = ev_ff;
                  wp_in    = run_ff ? start_ff : ev_ff;
                  start_in = run_ff ? start_ff : ev_ff;
                  pend_in  = 1'b0;
                  state_in = ffbc_pkg::ST_WRITE;
               end else if (ev_ff == LAST_IDX) begin
                  start_in = '0;
                  pend_in  = 1'b0;
                  state_in = ffbc_pkg::ST_DONE;
               end
            end
         end
         ffbc_pkg::ST_FREE: begin
            if (pend_ff) begin
               wr.en   = 1'b1;
               wr.addr = ev_ff;
               wr.data = '0;
               if (!rd_data.chained || ev_ff == LAST_IDX) begin
                  pend_in  = 1'b0;
                  state_in = ffbc_pkg::ST_DONE;
               end
            end
         end
         ffbc_pkg::ST_WRITE: begin
            wr.en           = 1'b1;
            wr.addr         = wp_ff;
            wr.data.used    = 1'b1;
            wr.data.chained = (wp_ff != end_ff);
            if (wp_ff == end_ff) begin
               state_in = ffbc_pkg::ST_DONE;
            end else begin
               wp_in = wp_ff + 1'b1;
            end
         end
         ffbc_pkg::ST_DONE: begin
            result.valid = 1'b1;
            result.ok    = ok_ff;
            result.start = ok_ff ? start_ff : '0;
            if (result_take) begin
               state_in = ffbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffbc_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffbc_pkg::ST_IDLE || state_ff == ffbc_pkg::ST_DONE) |-> !wr.en)
      else $error("mark store written outside a walk");

   a_claim_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffbc_pkg::ST_WRITE) |-> (wp_ff >= start_ff && wp_ff <= end_ff))
      else $error("claim write outside the granted run");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("new beat taken while previous one still in work");

   a_free_result_zero: assert property (@(posedge clock) disable iff (reset)
      (result.valid && !result.ok) |-> (result.start == '0))
      else $error("failed allocate reports a start block");
`endif

endmodule
`default_nettype wire

// ----- design/first_fit_block_chain_allocator.sv -----
// Top level of the first-fit block chain allocator.
// Keeps used and chain marks for up to 16 blocks (small, then middle, then large class) in a
// synchronous store with one read and one write port and serves one command at a time. An
// allocate walks the marks from block 0 at one block per cycle until the first free run that
// covers the byte count, then writes the run back one block per cycle; a zero-size request
// fails without a scan. A free walks the chain from the named block, one block per cycle.
// The store takes one read a cycle while scanning and one write a cycle while claiming or
// freeing.
// The result sits in an output register, so the next command can be taken while it waits.
`default_nettype none
module first_fit_block_chain_allocator #(
   parameter int SMALL_BLOCKS  = 8,
   parameter int MIDDLE_BLOCKS = 4,
   parameter int LARGE_BLOCKS  = 4,
   parameter int SMALL_BYTES   = 1024,
   parameter int MIDDLE_BYTES  = 2048,
   parameter int LARGE_BYTES   = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // request_size [15:0], block_index [19:16], zero pad
   input  wire logic        req_tuser,   // cmd: 0 allocate, 1 free
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // start_block [3:0], zero pad
   output logic             rsp_tuser    // ok
);

   logic                              req_accept;
   logic [ffbc_pkg::IDX_W-1:0]        rd_addr;
   ffbc_pkg::entry_type               rd_data;
   ffbc_pkg::mem_wr_type              wr;
   ffbc_pkg::result_type              result;
   logic                              result_take;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic [ffbc_pkg::IDX_W-1:0]        rsp_start_ff, rsp_start_in;

   assign req_accept  = req_tvalid && req_tready;
   assign result_take = !rsp_valid_ff || rsp_tready;

   ffbc_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   ffbc_ctrl #(
      .SMALL_BLOCKS  (SMALL_BLOCKS),
      .MIDDLE_BLOCKS (MIDDLE_BLOCKS),
      .LARGE_BLOCKS  (LARGE_BLOCKS),
      .SMALL_BYTES   (SMALL_BYTES),
      .MIDDLE_BYTES  (MIDDLE_BYTES),
      .LARGE_BYTES   (LARGE_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_cmd     (req_tuser),
      .req_size    (req_tdata[15:0]),
      .req_index   (req_tdata[19:16]),
      .req_ready   (req_tready),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr          (wr),
      .result      (result),
      .result_take (result_take)
   );

   // load the output register when it is empty or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_start_in = rsp_start_ff;
      if (result_take) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_ok_in    = result.ok;
            rsp_start_in = result.start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {4'b0, rsp_start_ff};

endmodule
`default_nettype wire
